[hdl/assert_macros.svh]
// Assertion helper macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked on every rising edge of clk, off while reset is asserted.
`define CHK_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("check failed");
// Implication whose consequent is checked in the cycle after the antecedent.
`define CHK_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("check failed");
`endif

[hdl/rfptu_pkg.sv]
// ----------------------------------------------------------------------------
// rfptu_pkg
// Shared types and constants for the packed-to-triangular unpack unit.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
package rfptu_pkg;
	localparam int MAX_N = 256;
	localparam int NW = 9;
	localparam int IW = 16;

	localparam logic [1:0] ST_OK = 2'd0;
	localparam logic [1:0] ST_LDA = 2'd1;
	localparam logic [1:0] ST_RANGE = 2'd2;

	localparam logic [1:0] REG_CONJ = 2'd0;
	localparam logic [1:0] REG_LOWER = 2'd1;
	localparam logic [1:0] REG_SIZE = 2'd2;
	localparam logic [1:0] REG_LDA = 2'd3;

	// Output word: fields from the highest bit down.
	typedef struct packed {
		logic [1:0]  status;
		logic        is_last;
		logic [63:0] out_im;
		logic [63:0] out_re;
		logic [7:0]  dest_col;
		logic [7:0]  dest_row;
		logic [15:0] dest_addr;
	} res_t;

	// Configuration values seen by the mapping logic.
	typedef struct packed {
		logic          conj;
		logic          lower;
		logic [NW-1:0] size_n;
		logic [NW-1:0] lead_dim;
	} cfg_t;
endpackage
`default_nettype wire

[hdl/rfptu_locate.sv]
// ----------------------------------------------------------------------------
// rfptu_locate
// Maps a packed rectangle position to its destination row, column and flip.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module rfptu_locate (
	input  wire logic [8:0] n,
	input  wire logic [2:0] seg,
	input  wire logic [8:0] r,
	input  wire logic [8:0] c,
	output logic [9:0]      row,
	output logic [9:0]      col,
	output logic            flip
);
	logic [9:0] h, g, rr, cc, j;

	always_comb begin
		h = {2'b0, n[8:1]};
		g = {1'b0, n} - h;
		rr = {1'b0, r};
		cc = {1'b0, c};
		j = '0;
		row = '0;
		col = '0;
		flip = 1'b0;
		case (seg)
			3'b101: begin
				if (rr < cc) begin row = h + cc; col = g + rr; flip = 1'b1; end
				else begin row = rr; col = cc; end
			end
			3'b001, 3'b000: begin
				j = h + cc;
				if (rr <= j) begin row = rr; col = j; end
				else begin row = cc; col = rr - h - 10'd1; flip = 1'b1; end
			end
			3'b111: begin
				if (cc < h && rr > cc) begin row = g + rr - 10'd1; col = g + cc; end
				else begin row = cc; col = rr; flip = 1'b1; end
			end
			3'b011: begin
				if (cc <= h) begin row = cc; col = h + rr; flip = 1'b1; end
				else begin
					j = cc - g;
					if (rr <= j) begin row = rr; col = j; end
					else begin row = g + j; col = g + rr - 10'd1; flip = 1'b1; end
				end
			end
			3'b100: begin
				if (rr <= cc) begin row = h + cc; col = h + rr; flip = 1'b1; end
				else begin row = rr - 10'd1; col = cc; end
			end
			3'b110: begin
				if (cc == 10'd0) begin row = h + rr; col = h; end
				else begin
					j = cc - 10'd1;
					if (rr <= j) begin row = j; col = rr; flip = 1'b1; end
					else begin row = h + rr; col = h + cc; end
				end
			end
			default: begin
				if (cc <= h) begin row = cc; col = h + rr; flip = 1'b1; end
				else begin
					j = cc - h - 10'd1;
					if (rr <= j) begin row = rr; col = j; end
					else begin row = h + 10'd1 + j; col = h + rr; flip = 1'b1; end
				end
			end
		endcase
	end
endmodule
`default_nettype wire

[hdl/rfp_to_triangular_unpack_unit.sv]
// ----------------------------------------------------------------------------
// rfp_to_triangular_unpack_unit
// Unpacks a Hermitian matrix streamed in RFP order into triangular addresses.
// ----------------------------------------------------------------------------
// Channel   Direction  tdata fields (low bit up)                   tuser/tlast
// s_axis    in         elem_re[63:0], elem_im[63:0]                  -
// m_axis    out        dest_addr, dest_row, dest_col, out_re, out_im tlast=is_last, tuser=status
// cfg       in         wr_en, wr_index[1:0], wr_data[8:0]             -
//
// One word is accepted per cycle while the output is not stalled. The walk
// counters and the input register form stage 1; the mapping and the address
// multiply feed the result register of stage 2, so a word passes the input
// register and then the result register before it is offered on the output.
// A stalled output holds stage 2, and stage 1 waits behind it.
// Reset clears all control state and loads the register reset values.
`timescale 1ns / 1ps
`default_nettype none
module rfp_to_triangular_unpack_unit (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         s_axis_tvalid,
	output logic              s_axis_tready,
	input  wire logic [127:0] s_axis_tdata,   // elem_re, elem_im
	output logic              m_axis_tvalid,
	input  wire logic         m_axis_tready,
	output logic [167:0]      m_axis_tdata,   // dest_addr, dest_row, dest_col, out_re, out_im
	output logic              m_axis_tlast,   // is_last
	output logic [1:0]        m_axis_tuser,   // status
	input  wire logic         wr_en,
	input  wire logic [1:0]   wr_index,
	input  wire logic [8:0]   wr_data
);
	rfptu_pkg::cfg_t cfg_q;
	logic [15:0] pidx_q;
	logic [8:0]  outer_q, inner_q;
	logic [2:0]  seg_q;

	// Stage 1: captured word with its position.
	logic        v_s1;
	logic [63:0] re_s1, im_s1;
	logic [8:0]  r_s1, c_s1;
	logic [1:0]  st_s1;
	logic        last_s1;
	// Stage 2: result.
	logic        v_s2;
	rfptu_pkg::res_t res_s2;

	logic adv_s2, adv_s1, take;
	logic [8:0] need, ldr;
	logic [16:0] nt;
	logic [1:0] st_now;
	logic last_now;
	logic [9:0] row, col;
	logic flip;
	logic [8:0] seg_next_n;

	assign adv_s2 = !v_s2 || m_axis_tready;
	assign adv_s1 = !v_s1 || adv_s2;
	assign s_axis_tready = adv_s1;
	assign take = s_axis_tvalid && s_axis_tready;

	always_comb begin
		need = (cfg_q.size_n > 9'd1) ? cfg_q.size_n : 9'd1;
		nt = 17'(({8'b0, cfg_q.size_n} * ({8'b0, cfg_q.size_n} + 17'd1)) >> 1);
		ldr = cfg_q.conj ? 9'((10'(cfg_q.size_n) + 10'd1) >> 1)
			: (cfg_q.size_n[0] ? cfg_q.size_n : cfg_q.size_n + 9'd1);
		last_now = 1'b0;
		if (cfg_q.lead_dim < need) st_now = rfptu_pkg::ST_LDA;
		else if (cfg_q.size_n == 9'd0 || 32'(cfg_q.size_n) > rfptu_pkg::MAX_N)
			st_now = rfptu_pkg::ST_RANGE;
		else if ({1'b0, pidx_q} >= nt) st_now = rfptu_pkg::ST_RANGE;
		else begin
			st_now = rfptu_pkg::ST_OK;
			last_now = ({1'b0, pidx_q} == nt - 17'd1);
		end
	end

	assign seg_next_n = 9'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '{conj: 1'b0, lower: 1'b1, size_n: 9'd0, lead_dim: 9'd1};
			pidx_q <= '0; outer_q <= '0; inner_q <= '0; seg_q <= 3'b100;
		end else if (wr_en) begin
			unique case (wr_index)
				rfptu_pkg::REG_CONJ: begin
					cfg_q.conj <= wr_data[0]; seg_q[1] <= wr_data[0];
				end
				rfptu_pkg::REG_LOWER: begin
					cfg_q.lower <= wr_data[0]; seg_q[2] <= wr_data[0];
				end
				rfptu_pkg::REG_SIZE: begin
					cfg_q.size_n <= wr_data; seg_q[0] <= wr_data[0];
				end
				default: cfg_q.lead_dim <= wr_data;
			endcase
			pidx_q <= '0; outer_q <= seg_next_n; inner_q <= '0;
		end else if (take) begin
			if (st_now == rfptu_pkg::ST_RANGE && cfg_q.lead_dim >= need
				&& cfg_q.size_n != 9'd0 && 32'(cfg_q.size_n) <= rfptu_pkg::MAX_N) begin
				pidx_q <= '0; outer_q <= '0; inner_q <= '0;
			end else if (st_now == rfptu_pkg::ST_OK) begin
				if (last_now) begin
					pidx_q <= '0; outer_q <= '0; inner_q <= '0;
				end else begin
					pidx_q <= pidx_q + 16'd1;
					if (inner_q + 9'd1 < ldr) inner_q <= inner_q + 9'd1;
					else begin inner_q <= '0; outer_q <= outer_q + 9'd1; end
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0; v_s2 <= 1'b0;
		end else begin
			if (adv_s1) v_s1 <= take;
			if (adv_s2) v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			re_s1 <= s_axis_tdata[63:0];
			im_s1 <= s_axis_tdata[127:64];
			r_s1 <= inner_q; c_s1 <= outer_q;
			st_s1 <= st_now; last_s1 <= last_now;
		end
	end

	// User keeps configuration stable while words are in flight, unchecked; stage 1 reads it.
	rfptu_locate u_loc (
		.n(cfg_q.size_n), .seg(seg_q), .r(r_s1), .c(c_s1),
		.row(row), .col(col), .flip(flip)
	);

	always_ff @(posedge clk) begin
		if (adv_s2 && v_s1) begin
			if (st_s1 == rfptu_pkg::ST_OK) begin
				res_s2.dest_addr <= 16'({8'b0, row} + 18'(col) * 18'(cfg_q.lead_dim));
				res_s2.dest_row <= row[7:0];
				res_s2.dest_col <= col[7:0];
				res_s2.out_re <= re_s1;
				res_s2.out_im <= {im_s1[63] ^ flip, im_s1[62:0]};
				res_s2.is_last <= last_s1;
			end else begin
				res_s2.dest_addr <= '0; res_s2.dest_row <= '0; res_s2.dest_col <= '0;
				res_s2.out_re <= '0; res_s2.out_im <= '0; res_s2.is_last <= 1'b0;
			end
			res_s2.status <= st_s1;
		end
	end

	assign m_axis_tvalid = v_s2;
	assign m_axis_tdata = {8'b0, res_s2.out_im, res_s2.out_re, res_s2.dest_col,
		res_s2.dest_row, res_s2.dest_addr};
	assign m_axis_tlast = res_s2.is_last;
	assign m_axis_tuser = res_s2.status;
endmodule
`default_nettype wire

[hdl/rfptu_checker.sv]
// ----------------------------------------------------------------------------
// rfptu_checker
// Port-level checks for the unpack unit, bound to its top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module rfptu_checker (
	input wire logic         clk,
	input wire logic         arst_n,
	input wire logic         m_axis_tvalid,
	input wire logic         m_axis_tready,
	input wire logic [167:0] m_axis_tdata,
	input wire logic         m_axis_tlast,
	input wire logic [1:0]   m_axis_tuser
);
	`CHK_NEXT(a_hold, clk, arst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata))
	`CHK_IMPL(a_status, clk, arst_n, m_axis_tvalid, m_axis_tuser != 2'd3)
	`CHK_IMPL(a_err_zero, clk, arst_n, m_axis_tvalid && m_axis_tuser != rfptu_pkg::ST_OK, m_axis_tdata == '0 && !m_axis_tlast)
endmodule
bind rfp_to_triangular_unpack_unit rfptu_checker u_chk (.*);
`default_nettype wire
